FILE: sv/saefb_pkg.sv
// Shared constants, mode codes and the saturation helper for the stereo effect filter bank.
package saefb_pkg;

	localparam int SMP_W    = 16;
	localparam int HP_LOG   = 3;   // 8-tap high-pass window
	localparam int BPS_LOG  = 2;   // 4-tap short band-pass window
	localparam int BPL_LOG  = 6;   // 64-tap long band-pass window
	localparam int ECS_LOG  = 2;   // 4-tap echo smoothing window
	localparam int ECHO_LOG = 11;  // 2048-deep echo delay line

	localparam int HP_TAPS  = 1 << HP_LOG;
	localparam int BPS_TAPS = 1 << BPS_LOG;
	localparam int ECS_TAPS = 1 << ECS_LOG;
	localparam int BPL_TAPS = 1 << BPL_LOG;
	localparam int ECHO_DEPTH = 1 << ECHO_LOG;

	localparam int HP_SUM_W  = SMP_W + HP_LOG;
	localparam int BPS_SUM_W = SMP_W + BPS_LOG;
	localparam int BPL_SUM_W = SMP_W + BPL_LOG;
	localparam int ECS_SUM_W = SMP_W + ECS_LOG;

	localparam int WIDE_W = SMP_W + 2;

	localparam logic [1:0] MODE_HP     = 2'd0;
	localparam logic [1:0] MODE_BP     = 2'd1;
	localparam logic [1:0] MODE_ECHO   = 2'd2;
	localparam logic [1:0] MODE_BYPASS = 2'd3;

	typedef logic signed [SMP_W-1:0]  smp_t;
	typedef logic signed [WIDE_W-1:0] wide_t;

	// Clamp a widened intermediate to the signed sample range.
	function automatic smp_t sat16(input wide_t v);
		smp_t r;
		if (v > 18'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -18'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[SMP_W-1:0];
		end
		return r;
	endfunction

	// Sign-extend a sample into the widened intermediate format.
	function automatic wide_t widen(input smp_t v);
		return {{(WIDE_W-SMP_W){v[SMP_W-1]}}, v};
	endfunction

endpackage

FILE: sv/stereo_audio_effect_filter_bank.sv
// Stereo audio effect filter bank: high-pass, mono band-pass, mono echo and bypass.
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+-----------------------------------------
//  s_axis   | s_axis_tvalid / s_axis_tready  | tdata[15:0] left_in, [31:16] right_in
//  m_axis   | m_axis_tvalid / m_axis_tready  | tdata[15:0] left_out, [31:16] right_out
//  cfg      | cfg_valid / cfg_ready          | cfg_data[1:0] filter_mode
//
// A word is accepted on s_axis in every cycle when the output side keeps up. Its result
// passes from the stage 1 register into the output register, from which it leaves on
// m_axis. The stage 1 register serves the registered read port of the 64-tap band-pass
// window memory and the echo delay line memory: the read is launched as the word is
// accepted and the arithmetic runs in the next stage.
// Reset clears all control state at once and needs no clearing pass: a lap flag per
// memory marks entries not yet written in this run, and those read as zero.
// A stalled output register holds its word and the stage before it holds as well, so
// s_axis_tready drops only while both stages are full and m_axis_tready is low.
module stereo_audio_effect_filter_bank
	import saefb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [15:0] left_in, [31:16] right_in
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [15:0] left_out, [31:16] right_out
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data        // [1:0] filter_mode
);

	// Mode register.
	logic [1:0] mode_q;

	// Pipeline control.
	logic s1_v_q;
	logic out_v_q;
	logic out_adv;
	logic s1_adv;
	logic acc;

	// Stage 1 payload.
	smp_t left_s1, right_s1;
	logic [BPL_LOG-1:0]  bpl_addr_s1;
	logic [ECHO_LOG-1:0] echo_addr_s1;
	logic bpl_hit_s1, echo_hit_s1;

	// Output register.
	smp_t left_q, right_q;

	// High-pass state.
	smp_t hpl_win_q [HP_TAPS];
	smp_t hpr_win_q [HP_TAPS];
	logic [HP_SUM_W-1:0] hpl_sum_q, hpr_sum_q;
	logic [HP_LOG-1:0]   hpl_idx_q, hpr_idx_q;

	// Band-pass state.
	smp_t bps_win_q [BPS_TAPS];
	logic [BPS_SUM_W-1:0] bps_sum_q;
	logic [BPS_LOG-1:0]   bps_idx_q;
	smp_t bpl_mem [BPL_TAPS];
	smp_t bpl_rd_q;
	logic [BPL_SUM_W-1:0] bpl_sum_q;
	logic [BPL_LOG-1:0]   bpl_idx_q;
	logic bpl_lap_q;

	// Echo state.
	smp_t ecs_win_q [ECS_TAPS];
	logic [ECS_SUM_W-1:0] ecs_sum_q;
	logic [ECS_LOG-1:0]   ecs_idx_q;
	smp_t echo_mem [ECHO_DEPTH];
	smp_t echo_rd_q;
	logic [ECHO_LOG-1:0] echo_idx_q;
	logic echo_lap_q;

	// Stage 1 arithmetic.
	smp_t hpl_old, hpr_old, hpl_avg, hpr_avg;
	logic [HP_SUM_W-1:0] hpl_sum_nx, hpr_sum_nx;
	wide_t hpl_diff, hpr_diff;
	logic [SMP_W:0] mono_sum;
	smp_t mono;
	smp_t bps_old, bps_avg, bpl_old, bpl_avg;
	logic [BPS_SUM_W-1:0] bps_sum_nx;
	logic [BPL_SUM_W-1:0] bpl_sum_nx;
	wide_t bp_d, bp_q4, bp_v;
	smp_t ecs_old, ecs_avg, echo_old, echo_v;
	logic [ECS_SUM_W-1:0] ecs_sum_nx;
	smp_t left_nx, right_nx;

	assign cfg_ready     = 1'b1;
	assign out_adv       = !out_v_q || m_axis_tready;
	assign s1_adv        = s1_v_q && out_adv;
	assign s_axis_tready = !s1_v_q || out_adv;
	assign acc           = s_axis_tvalid && s_axis_tready;

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {right_q, left_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_BYPASS;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	// Running sums: add the newest sample and drop the one it replaces. The average is
	// the sum with its low log2(tap count) bits dropped, which is a floor shift.
	always_comb begin
		hpl_old    = hpl_win_q[hpl_idx_q];
		hpr_old    = hpr_win_q[hpr_idx_q];
		hpl_sum_nx = hpl_sum_q + {{HP_LOG{left_s1[SMP_W-1]}}, left_s1}
			- {{HP_LOG{hpl_old[SMP_W-1]}}, hpl_old};
		hpr_sum_nx = hpr_sum_q + {{HP_LOG{right_s1[SMP_W-1]}}, right_s1}
			- {{HP_LOG{hpr_old[SMP_W-1]}}, hpr_old};
		hpl_avg    = smp_t'(hpl_sum_nx[HP_SUM_W-1:HP_LOG]);
		hpr_avg    = smp_t'(hpr_sum_nx[HP_SUM_W-1:HP_LOG]);
		hpl_diff   = widen(left_s1) - widen(hpl_avg);
		hpr_diff   = widen(right_s1) - widen(hpr_avg);

		mono_sum = {left_s1[SMP_W-1], left_s1} + {right_s1[SMP_W-1], right_s1};
		mono     = smp_t'(mono_sum[SMP_W:1]);

		bps_old    = bps_win_q[bps_idx_q];
		bps_sum_nx = bps_sum_q + {{BPS_LOG{mono[SMP_W-1]}}, mono}
			- {{BPS_LOG{bps_old[SMP_W-1]}}, bps_old};
		bps_avg    = smp_t'(bps_sum_nx[BPS_SUM_W-1:BPS_LOG]);
		bpl_old    = bpl_hit_s1 ? bpl_rd_q : '0;
		bpl_sum_nx = bpl_sum_q + {{BPL_LOG{mono[SMP_W-1]}}, mono}
			- {{BPL_LOG{bpl_old[SMP_W-1]}}, bpl_old};
		bpl_avg    = smp_t'(bpl_sum_nx[BPL_SUM_W-1:BPL_LOG]);
		bp_d       = widen(bps_avg) - widen(bpl_avg);
		bp_q4      = bp_d >>> 2;
		bp_v       = bp_d - bp_q4;

		ecs_old    = ecs_win_q[ecs_idx_q];
		ecs_sum_nx = ecs_sum_q + {{ECS_LOG{mono[SMP_W-1]}}, mono}
			- {{ECS_LOG{ecs_old[SMP_W-1]}}, ecs_old};
		ecs_avg    = smp_t'(ecs_sum_nx[ECS_SUM_W-1:ECS_LOG]);
		echo_old   = echo_hit_s1 ? echo_rd_q : '0;
		// Both halves lie within half of full scale, so the echo sum never overflows.
		echo_v     = (ecs_avg >>> 1) + (echo_old >>> 1);

		unique case (mode_q)
			MODE_HP: begin
				left_nx  = sat16(hpl_diff);
				right_nx = sat16(hpr_diff);
			end
			MODE_BP: begin
				left_nx  = sat16(bp_v);
				right_nx = sat16(bp_v);
			end
			MODE_ECHO: begin
				left_nx  = echo_v;
				right_nx = echo_v;
			end
			default: begin
				left_nx  = left_s1;
				right_nx = right_s1;
			end
		endcase
	end

	// Memory read ports: the read of the oldest entry is launched as a word is accepted.
	always_ff @(posedge clk) begin
		if (acc) begin
			bpl_rd_q  <= bpl_mem[bpl_idx_q];
			echo_rd_q <= echo_mem[echo_idx_q];
		end
	end

	// Memory write ports: the entry read for the word in stage 1 is replaced as it leaves.
	// While the mode holds, the next read is one address further on, so the two never collide.
	always_ff @(posedge clk) begin
		if (s1_adv && mode_q == MODE_BP) begin
			bpl_mem[bpl_addr_s1] <= mono;
		end
		if (s1_adv && mode_q == MODE_ECHO) begin
			echo_mem[echo_addr_s1] <= echo_v;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			left_s1      <= smp_t'(s_axis_tdata[SMP_W-1:0]);
			right_s1     <= smp_t'(s_axis_tdata[2*SMP_W-1:SMP_W]);
			bpl_addr_s1  <= bpl_idx_q;
			echo_addr_s1 <= echo_idx_q;
			bpl_hit_s1   <= bpl_lap_q;
			echo_hit_s1  <= echo_lap_q;
		end
		if (s1_adv) begin
			left_q  <= left_nx;
			right_q <= right_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				s1_v_q <= s_axis_tvalid;
			end
			if (out_adv) begin
				out_v_q <= s1_v_q;
			end
		end
	end

	// Pointers move at acceptance in their mode; a lap flag is set once every entry holds data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpl_idx_q  <= '0;
			bpl_lap_q  <= 1'b0;
			echo_idx_q <= '0;
			echo_lap_q <= 1'b0;
		end else if (acc) begin
			if (mode_q == MODE_BP) begin
				bpl_idx_q <= bpl_idx_q + 1'b1;
				if (&bpl_idx_q) begin
					bpl_lap_q <= 1'b1;
				end
			end
			if (mode_q == MODE_ECHO) begin
				echo_idx_q <= echo_idx_q + 1'b1;
				if (&echo_idx_q) begin
					echo_lap_q <= 1'b1;
				end
			end
		end
	end

	// In the selected mode, register windows and running sums advance as a word leaves stage 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HP_TAPS; i++) begin
				hpl_win_q[i] <= '0;
				hpr_win_q[i] <= '0;
			end
			for (int i = 0; i < BPS_TAPS; i++) begin
				bps_win_q[i] <= '0;
			end
			for (int i = 0; i < ECS_TAPS; i++) begin
				ecs_win_q[i] <= '0;
			end
			hpl_sum_q <= '0;
			hpr_sum_q <= '0;
			hpl_idx_q <= '0;
			hpr_idx_q <= '0;
			bps_sum_q <= '0;
			bps_idx_q <= '0;
			bpl_sum_q <= '0;
			ecs_sum_q <= '0;
			ecs_idx_q <= '0;
		end else if (s1_adv) begin
			unique case (mode_q)
				MODE_HP: begin
					hpl_win_q[hpl_idx_q] <= left_s1;
					hpr_win_q[hpr_idx_q] <= right_s1;
					hpl_sum_q <= hpl_sum_nx;
					hpr_sum_q <= hpr_sum_nx;
					hpl_idx_q <= hpl_idx_q + 1'b1;
					hpr_idx_q <= hpr_idx_q + 1'b1;
				end
				MODE_BP: begin
					bps_win_q[bps_idx_q] <= mono;
					bps_sum_q <= bps_sum_nx;
					bps_idx_q <= bps_idx_q + 1'b1;
					bpl_sum_q <= bpl_sum_nx;
				end
				MODE_ECHO: begin
					ecs_win_q[ecs_idx_q] <= mono;
					ecs_sum_q <= ecs_sum_nx;
					ecs_idx_q <= ecs_idx_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// A word may enter a full stage 1 only when the stage's word moves on in that cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(acc && s1_v_q) |-> out_adv)
		else $error("word accepted over a held stage 1 word");

	// The lap flags can only come up as their pointer wraps back to the first entry.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(echo_lap_q) |-> (echo_idx_q == '0))
		else $error("echo lap flag set away from pointer wrap");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(bpl_lap_q) |-> (bpl_idx_q == '0))
		else $error("band-pass lap flag set away from pointer wrap");

	// Output valid comes up only after a word sat in stage 1.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s1_v_q))
		else $error("output valid without a stage 1 word");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the stereo audio effect filter bank: random stimulus, scoreboard.
module testbench;
	import saefb_pkg::*;

	// Window sizes as shift counts; every tap count is a power of two.
	localparam int HP_SHIFT    = 3;
	localparam int BPS_SHIFT   = 2;
	localparam int BPL_SHIFT   = 6;
	localparam int ECS_SHIFT   = 2;
	localparam int ECHO_LEN    = 2048;
	localparam int WIN_MAX     = 64;
	localparam int N_WINDOWS   = 5;

	localparam smp_t SMP_MAX = 16'sh7fff;
	localparam smp_t SMP_MIN = 16'sh8000;

	localparam int LONG_HOLD_CYCLES = 100;
	localparam int N_PHASES         = 9;

	// Random phases. The echo phases are the longest so that a large part of the delay
	// line fills; the band-pass phases together pass the length of the long window.
	localparam logic [1:0] PLAN_MODE [N_PHASES] = '{MODE_HP, MODE_BP, MODE_ECHO,
		MODE_BYPASS, MODE_BP, MODE_ECHO, MODE_HP, MODE_BYPASS, MODE_ECHO};
	localparam int PLAN_LEN [N_PHASES] = '{40, 40, 520, 40, 40, 520, 40, 40, 520};

	typedef enum int {
		WIN_HP_L,
		WIN_HP_R,
		WIN_BP_SHORT,
		WIN_BP_LONG,
		WIN_ECHO_SMOOTH
	} window_e;

	// The scoreboard keeps its own copy of every window, running sum and the delay
	// line, computes the expected pair for each accepted input word, and checks the
	// output words against those pairs in order.
	class filter_scoreboard;
		logic [1:0] mode;
		int win_data [N_WINDOWS][WIN_MAX];
		int win_sum [N_WINDOWS];
		int win_pos [N_WINDOWS];
		int echo_line [ECHO_LEN];
		int echo_pos;
		smp_t want_left [$];
		smp_t want_right [$];
		int errors;

		function new();
			mode = MODE_BYPASS;
			errors = 0;
			echo_pos = 0;
		endfunction

		function int window_shift(window_e w);
			case (w)
				WIN_HP_L, WIN_HP_R: return HP_SHIFT;
				WIN_BP_SHORT: return BPS_SHIFT;
				WIN_BP_LONG: return BPL_SHIFT;
				default: return ECS_SHIFT;
			endcase
		endfunction

		// Replaces the oldest sample of a window and returns the floor of its mean.
		function int mean_push(window_e w, int x);
			int p;
			int sh;
			p = win_pos[w];
			sh = window_shift(w);
			win_sum[w] += x - win_data[w][p];
			win_data[w][p] = x;
			win_pos[w] = (p + 1) % (1 << sh);
			return win_sum[w] >>> sh;
		endfunction

		function smp_t clamp(int v);
			if (v > 32767) begin
				return SMP_MAX;
			end
			if (v < -32768) begin
				return SMP_MIN;
			end
			return smp_t'(v);
		endfunction

		function void note_word(logic [31:0] word);
			int l, r, m, a, b, v;
			l = int'(smp_t'(word[15:0]));
			r = int'(smp_t'(word[31:16]));
			case (mode)
				MODE_HP: begin
					a = mean_push(WIN_HP_L, l);
					b = mean_push(WIN_HP_R, r);
					l -= a;
					r -= b;
				end
				MODE_BP: begin
					m = (l + r) >>> 1;
					a = mean_push(WIN_BP_SHORT, m);
					b = mean_push(WIN_BP_LONG, m);
					v = a - b;
					v -= v >>> 2;
					l = v;
					r = v;
				end
				MODE_ECHO: begin
					m = (l + r) >>> 1;
					a = mean_push(WIN_ECHO_SMOOTH, m);
					b = echo_line[echo_pos];
					v = (a >>> 1) + (b >>> 1);
					echo_line[echo_pos] = v;
					echo_pos = (echo_pos + 1) % ECHO_LEN;
					l = v;
					r = v;
				end
				default: begin
				end
			endcase
			want_left.push_back(clamp(l));
			want_right.push_back(clamp(r));
		endfunction

		function void check_word(logic [31:0] word);
			smp_t got_l, got_r, exp_l, exp_r;
			got_l = word[15:0];
			got_r = word[31:16];
			if (want_left.size() == 0) begin
				$error("output word with nothing expected: left_out %0d, right_out %0d",
					got_l, got_r);
				errors++;
				return;
			end
			exp_l = want_left.pop_front();
			exp_r = want_right.pop_front();
			if (got_l !== exp_l) begin
				$error("left_out mismatch: expected %0d, actual %0d", exp_l, got_l);
				errors++;
			end
			if (got_r !== exp_r) begin
				$error("right_out mismatch: expected %0d, actual %0d", exp_r, got_r);
				errors++;
			end
		endfunction

		function int pending();
			return want_left.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;   // [15:0] left_in, [31:16] right_in
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b1;
	logic [31:0] m_axis_tdata;        // [15:0] left_out, [31:16] right_out
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_data = MODE_BYPASS;   // [1:0] filter_mode

	filter_scoreboard sb = new();

	// When quiet is set neither side idles; long_hold asks the receiver for one long
	// stall while the sender keeps offering words.
	bit quiet = 1'b0;
	bit long_hold = 1'b0;

	// State of the run generator: a run repeats one extreme pair for a while so that
	// the averaging windows fill up with full-scale values and the outputs saturate.
	int   run_count = 0;
	smp_t run_l = '0;
	smp_t run_r = '0;

	stereo_audio_effect_filter_bank uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #10 clk = ~clk;

	// Both channels are observed at the rising edge, where the values seen are the
	// ones that the edge samples. An output word can never come from the input word
	// accepted at the same edge, so the order of the two calls does not matter.
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			sb.check_word(m_axis_tdata);
		end
		if (s_axis_tvalid && s_axis_tready) begin
			sb.note_word(s_axis_tdata);
		end
	end

	// Receiver: random stalls, none while quiet, and one long stall on request so that both
	// pipeline stages fill and s_axis_tready drops.
	initial begin
		forever begin
			@(posedge clk);
			if (long_hold) begin
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				long_hold = 1'b0;
				m_axis_tready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Offers one pair and returns at the edge where the word is accepted. The valid
	// stays high so that a following word can go out at the very next edge.
	task automatic send_word(input smp_t l, input smp_t r);
		s_axis_tdata <= {r, l};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic sender_gap();
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// Stops offering and waits until every expected pair has come out. An edge always
	// passes first, so the last accepted word is surely on the books.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// The mode register is written only while the block holds no words.
	task automatic write_mode(input logic [1:0] m);
		wait_drained();
		cfg_data <= m;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.mode = m;
	endtask

	task automatic next_pair(output smp_t l, output smp_t r);
		if (run_count == 0 && $urandom_range(0, 11) == 0) begin
			run_count = $urandom_range(2, 80);
			run_l = $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
			run_r = $urandom_range(0, 2) != 0 ? run_l : ($urandom_range(0, 1) ? SMP_MAX : SMP_MIN);
		end
		if (run_count > 0) begin
			l = run_l;
			r = run_r;
			run_count--;
		end else begin
			case ($urandom_range(0, 7))
				4: begin
					l = $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
					r = $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
				end
				5: begin
					l = smp_t'(int'($urandom_range(0, 512)) - 256);
					r = smp_t'(int'($urandom_range(0, 512)) - 256);
				end
				6: begin
					l = smp_t'($urandom);
					r = l;
				end
				default: begin
					l = smp_t'($urandom);
					r = smp_t'($urandom);
				end
			endcase
		end
	endtask

	initial begin
		smp_t l, r;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Straight out of reset the mode is bypass, so the extremes pass unchanged.
		send_word(SMP_MAX, SMP_MIN);
		send_word(SMP_MIN, SMP_MAX);
		send_word(16'sd0, 16'sd0);
		send_word(-16'sd1, 16'sd1);

		// High-pass: three words at opposite extremes pull the means far enough that
		// the fourth word saturates high on the left and low on the right.
		write_mode(MODE_HP);
		repeat (3) send_word(SMP_MIN, SMP_MAX);
		send_word(SMP_MAX, SMP_MIN);

		// Band-pass: a full-scale step up and back down through both windows.
		write_mode(MODE_BP);
		repeat (4) send_word(SMP_MAX, SMP_MAX);
		repeat (2) send_word(SMP_MIN, SMP_MIN);

		// Echo: extremes, opposite channels that cancel, and an odd negative sum that
		// checks the floor of the mono mix.
		write_mode(MODE_ECHO);
		send_word(SMP_MAX, SMP_MAX);
		send_word(SMP_MIN, SMP_MIN);
		send_word(SMP_MAX, SMP_MIN);
		send_word(-16'sd1, 16'sd0);

		// Random phases. Each one starts with a mode write once the block is empty;
		// the effects that are not selected keep their state across phases.
		for (int p = 0; p < N_PHASES; p++) begin
			quiet = (p == N_PHASES - 1) || ($urandom_range(0, 3) == 0);
			write_mode(PLAN_MODE[p]);
			if (p == 1) begin
				long_hold = 1'b1;
			end
			for (int n = 0; n < PLAN_LEN[p]; n++) begin
				// Once in the run the sender waits for the block to run dry mid-phase.
				if (p == 3 && n == PLAN_LEN[p] / 2) begin
					wait_drained();
				end
				next_pair(l, r);
				send_word(l, r);
				sender_gap();
			end
		end

		// Let the last words out, then give any stray word time to show.
		wait_drained();
		repeat (4) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#10_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
